// ===== rtl/ital_pkg.sv =====
// Package for the indentation-aware token lexer: token codes, lexer modes,
// character classes and the result record shared by the core, queue and top.
// No dependencies.
package ital_pkg;

  // Default indent counter width and configuration reset value
  localparam int unsigned INDENT_BITS_DEF = 16;
  localparam logic [4:0]  TAB_WIDTH_RST   = 5'd4;

  // Result queue geometry
  localparam int unsigned RES_DEPTH = 8;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = RES_PTR_W + 1;

  // Token kinds
  localparam logic [3:0] KIND_INDENT   = 4'd0;
  localparam logic [3:0] KIND_COMMA    = 4'd1;
  localparam logic [3:0] KIND_ATOM     = 4'd2;
  localparam logic [3:0] KIND_RND_OPEN = 4'd3;
  localparam logic [3:0] KIND_RND_CLS  = 4'd4;
  localparam logic [3:0] KIND_SQR_OPEN = 4'd5;
  localparam logic [3:0] KIND_SQR_CLS  = 4'd6;
  localparam logic [3:0] KIND_BRC_OPEN = 4'd7;
  localparam logic [3:0] KIND_BRC_CLS  = 4'd8;
  localparam logic [3:0] KIND_STRING   = 4'd9;
  localparam logic [3:0] KIND_INTEGER  = 4'd10;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UPR_Z  = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LWR_Z  = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Lexer modes
  typedef enum logic [2:0] {
    MODE_LSTART,
    MODE_LINE,
    MODE_ATOM,
    MODE_NUM,
    MODE_STR,
    MODE_ESC
  } mode_e;

  // One result item
  typedef struct packed {
    logic [3:0]  token_kind;
    logic [7:0]  text_byte;
    logic        has_text;
    logic        token_begin;
    logic        token_end;
    logic [15:0] indent_width;
    logic [1:0]  error_code;
    logic        last_of_run;
  } result_t;

  // Results written to the queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

  // Decode of one byte in line mode
  typedef struct packed {
    logic    emit;
    result_t res;
    mode_e   mode;
    logic    to_lstart;
    logic    err;
  } line_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_atom_char(logic [7:0] c);
    logic hit;
    hit = (c == CH_EQUAL) || (c == CH_COLON) || (c == CH_BANG) || (c == CH_MINUS) ||
          (c == CH_PLUS) || (c == CH_STAR) || (c == CH_DOT);
    hit = hit || ((c >= CH_HASH) && (c <= CH_AMP));
    hit = hit || ((c >= CH_ZERO) && (c <= CH_UPR_Z));
    hit = hit || ((c >= CH_CARET) && (c <= CH_LWR_Z));
    return hit;
  endfunction

  function automatic logic [3:0] open_kind(logic [7:0] c);
    logic [3:0] k;
    k = KIND_INDENT;
    if (c == CH_LPAREN) k = KIND_RND_OPEN;
    if (c == CH_LBRACK) k = KIND_SQR_OPEN;
    if (c == CH_LBRACE) k = KIND_BRC_OPEN;
    return k;
  endfunction

  function automatic logic [3:0] single_kind(logic [7:0] c);
    logic [3:0] k;
    unique case (c)
      CH_COMMA:  k = KIND_COMMA;
      CH_LPAREN: k = KIND_RND_OPEN;
      CH_RPAREN: k = KIND_RND_CLS;
      CH_LBRACK: k = KIND_SQR_OPEN;
      CH_RBRACK: k = KIND_SQR_CLS;
      CH_LBRACE: k = KIND_BRC_OPEN;
      CH_RBRACE: k = KIND_BRC_CLS;
      default:   k = KIND_INDENT;
    endcase
    return k;
  endfunction

  function automatic result_t mk_res(logic [3:0] kind, logic [7:0] text, logic has,
                                     logic beg, logic fin, logic [15:0] ind,
                                     logic [1:0] err);
    result_t r;
    r.token_kind   = kind;
    r.text_byte    = text;
    r.has_text     = has;
    r.token_begin  = beg;
    r.token_end    = fin;
    r.indent_width = ind;
    r.error_code   = err;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // Lex one byte between tokens
  function automatic line_t lex_line(logic [7:0] c, logic eoc);
    line_t      l;
    logic [3:0] k;
    l      = '0;
    l.mode = MODE_LINE;
    k      = single_kind(c);
    if (eoc || (c == CH_NL)) begin
      l.to_lstart = 1'b1;
    end else if ((c == CH_SPACE) || (c == CH_TAB)) begin
      l.emit = 1'b0;
    end else if (k != KIND_INDENT) begin
      l.emit = 1'b1;
      l.res  = mk_res(k, 8'h00, 1'b0, 1'b1, 1'b1, 16'h0000, ERR_NONE);
    end else if (c == CH_QUOTE) begin
      l.emit = 1'b1;
      l.res  = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, ERR_NONE);
      l.mode = MODE_STR;
    end else if (is_digit(c)) begin
      l.emit = 1'b1;
      l.res  = mk_res(KIND_INTEGER, c, 1'b1, 1'b1, 1'b0, 16'h0000, ERR_NONE);
      l.mode = MODE_NUM;
    end else if (is_atom_char(c)) begin
      l.emit = 1'b1;
      l.res  = mk_res(KIND_ATOM, c, 1'b1, 1'b1, 1'b0, 16'h0000, ERR_NONE);
      l.mode = MODE_ATOM;
    end else begin
      l.emit      = 1'b1;
      l.res       = mk_res(KIND_INDENT, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, ERR_UNKNOWN);
      l.err       = 1'b1;
      l.to_lstart = 1'b1;
    end
    return l;
  endfunction

endpackage

// ===== rtl/ital_in_if.sv =====
// Input channel of the lexer: one source byte per transfer.
// Depends on nothing.
interface ital_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       end_of_code;

  modport source(output valid, output code_byte, output end_of_code, input ready);
  modport sink(input valid, input code_byte, input end_of_code, output ready);
endinterface

// ===== rtl/ital_out_if.sv =====
// Output channel of the lexer: one token result per transfer.
// Depends on nothing.
interface ital_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [7:0]  text_byte;
  logic        has_text;
  logic        token_begin;
  logic        token_end;
  logic [15:0] indent_width;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source(output valid, output token_kind, output text_byte, output has_text,
                 output token_begin, output token_end, output indent_width,
                 output error_code, output last_of_run, input ready);
  modport sink(input valid, input token_kind, input text_byte, input has_text,
               input token_begin, input token_end, input indent_width,
               input error_code, input last_of_run, output ready);
endinterface

// ===== rtl/ital_core.sv =====
// Lexer state machine: mode, indent counter and sticky error, plus the
// decode of one registered byte into up to two results. Uses ital_pkg.
module ital_core #(
  parameter int unsigned INDENT_BITS = ital_pkg::INDENT_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_vld_i,
  input  logic [7:0]      code_byte_i,
  input  logic            end_of_code_i,
  input  logic [4:0]      tab_width_i,
  output ital_pkg::push_t push_o
);

  localparam int unsigned SUM_W = INDENT_BITS + 6;
  localparam int unsigned EXT_W = (INDENT_BITS > 16) ? INDENT_BITS : 16;

  ital_pkg::mode_e        mode_q, mode_d;
  logic [INDENT_BITS-1:0] ind_q, ind_d;
  logic                   err_q, err_d;

  ital_pkg::line_t        ln;
  logic                   blank;
  logic [SUM_W-1:0]       ind_sum;
  logic [SUM_W-1:0]       ind_cap;
  logic [INDENT_BITS-1:0] ind_sat;
  logic [EXT_W-1:0]       ind_ext;
  logic [15:0]            ind_out;
  logic [3:0]             close_kind;
  logic [3:0]             open_k;
  ital_pkg::push_t        push;

  // Byte classes used by the next-state and result blocks
  always_comb begin
    ln     = ital_pkg::lex_line(code_byte_i, end_of_code_i);
    blank  = (code_byte_i == ital_pkg::CH_SPACE) || (code_byte_i == ital_pkg::CH_TAB);
    open_k = ital_pkg::open_kind(code_byte_i);
    close_kind = (!end_of_code_i && (open_k != ital_pkg::KIND_INDENT)) ?
                 open_k : ital_pkg::KIND_ATOM;
  end

  // Saturating indent add and the 16-bit reported width
  always_comb begin
    ind_cap = (SUM_W'(1) << INDENT_BITS) - SUM_W'(1);
    ind_sum = SUM_W'(ind_q) +
              ((code_byte_i == ital_pkg::CH_SPACE) ? SUM_W'(1) : SUM_W'(tab_width_i));
    ind_sat = (ind_sum > ind_cap) ? '1 : ind_sum[INDENT_BITS-1:0];
    ind_ext = EXT_W'(ind_q);
    ind_out = (ind_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF : ind_ext[15:0];
  end

  // Next state
  always_comb begin
    mode_d = mode_q;
    ind_d  = ind_q;
    err_d  = err_q;
    if (in_vld_i && !err_q) begin
      unique case (mode_q)
        ital_pkg::MODE_STR, ital_pkg::MODE_ESC: begin
          if (end_of_code_i) begin
            err_d  = 1'b1;
            mode_d = ital_pkg::MODE_LSTART;
            ind_d  = '0;
          end else if (mode_q == ital_pkg::MODE_ESC) begin
            mode_d = ital_pkg::MODE_STR;
          end else if (code_byte_i == ital_pkg::CH_QUOTE) begin
            mode_d = ital_pkg::MODE_LINE;
          end else if (code_byte_i == ital_pkg::CH_BSLASH) begin
            mode_d = ital_pkg::MODE_ESC;
          end
        end
        ital_pkg::MODE_ATOM, ital_pkg::MODE_NUM, ital_pkg::MODE_LSTART: begin
          if (mode_q == ital_pkg::MODE_ATOM && !end_of_code_i &&
              ital_pkg::is_atom_char(code_byte_i)) begin
            mode_d = mode_q;
          end else if (mode_q == ital_pkg::MODE_NUM && !end_of_code_i &&
                       ital_pkg::is_digit(code_byte_i)) begin
            mode_d = mode_q;
          end else if (mode_q == ital_pkg::MODE_LSTART && !end_of_code_i && blank) begin
            ind_d = ind_sat;
          end else begin
            mode_d = ln.to_lstart ? ital_pkg::MODE_LSTART : ln.mode;
            ind_d  = ln.to_lstart ? '0 : ind_q;
            err_d  = ln.err;
          end
        end
        default: begin
          mode_d = ln.to_lstart ? ital_pkg::MODE_LSTART : ln.mode;
          ind_d  = ln.to_lstart ? '0 : ind_q;
          err_d  = ln.err;
        end
      endcase
    end
  end

  // Results of this byte
  always_comb begin
    push = '0;
    if (in_vld_i && !err_q) begin
      unique case (mode_q)
        ital_pkg::MODE_STR, ital_pkg::MODE_ESC: begin
          push.cnt = 2'd1;
          if (end_of_code_i) begin
            push.res0 = ital_pkg::mk_res(ital_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1,
                                         16'h0000, ital_pkg::ERR_UNTERM);
          end else if ((mode_q == ital_pkg::MODE_STR) &&
                       (code_byte_i == ital_pkg::CH_QUOTE)) begin
            push.res0 = ital_pkg::mk_res(ital_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1,
                                         16'h0000, ital_pkg::ERR_NONE);
          end else begin
            push.res0 = ital_pkg::mk_res(ital_pkg::KIND_STRING, code_byte_i, 1'b1, 1'b0,
                                         1'b0, 16'h0000, ital_pkg::ERR_NONE);
          end
        end
        ital_pkg::MODE_ATOM: begin
          if (!end_of_code_i && ital_pkg::is_atom_char(code_byte_i)) begin
            push.cnt  = 2'd1;
            push.res0 = ital_pkg::mk_res(ital_pkg::KIND_ATOM, code_byte_i, 1'b1, 1'b0, 1'b0,
                                         16'h0000, ital_pkg::ERR_NONE);
          end else begin
            push.cnt  = ln.emit ? 2'd2 : 2'd1;
            push.res0 = ital_pkg::mk_res(close_kind, 8'h00, 1'b0, 1'b0, 1'b1,
                                         16'h0000, ital_pkg::ERR_NONE);
            push.res1 = ln.res;
          end
        end
        ital_pkg::MODE_NUM: begin
          if (!end_of_code_i && ital_pkg::is_digit(code_byte_i)) begin
            push.cnt  = 2'd1;
            push.res0 = ital_pkg::mk_res(ital_pkg::KIND_INTEGER, code_byte_i, 1'b1, 1'b0,
                                         1'b0, 16'h0000, ital_pkg::ERR_NONE);
          end else begin
            push.cnt  = ln.emit ? 2'd2 : 2'd1;
            push.res0 = ital_pkg::mk_res(ital_pkg::KIND_INTEGER, 8'h00, 1'b0, 1'b0, 1'b1,
                                         16'h0000, ital_pkg::ERR_NONE);
            push.res1 = ln.res;
          end
        end
        ital_pkg::MODE_LSTART: begin
          if (end_of_code_i || !blank) begin
            push.cnt  = ln.emit ? 2'd2 : 2'd1;
            push.res0 = ital_pkg::mk_res(ital_pkg::KIND_INDENT, 8'h00, 1'b0, 1'b1, 1'b1,
                                         ind_out, ital_pkg::ERR_NONE);
            push.res1 = ln.res;
          end
        end
        default: begin
          push.cnt  = ln.emit ? 2'd1 : 2'd0;
          push.res0 = ln.res;
        end
      endcase
      // mark the final result of this byte
      push.res0.last_of_run = (push.cnt == 2'd1);
      push.res1.last_of_run = (push.cnt == 2'd2);
    end
  end

  assign push_o = push;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ital_pkg::MODE_LSTART;
      ind_q  <= '0;
      err_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      ind_q  <= ind_d;
      err_q  <= err_d;
    end
  end

  // Sticky error silences the lexer
  assert property (@(posedge clk_i) disable iff (!rst_ni) err_q |-> (push.cnt == 2'd0))
    else $error("result produced after sticky error");

  // Inside a string each byte yields exactly one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_i && !err_q && (mode_q == ital_pkg::MODE_STR || mode_q == ital_pkg::MODE_ESC))
    |-> (push.cnt == 2'd1))
    else $error("string byte did not yield one result");

  // Indent counter only grows at line start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != ital_pkg::MODE_LSTART) |=> (ind_q == $past(ind_q)) || (ind_q == '0))
    else $error("indent counter changed outside line start");

endmodule

// ===== rtl/ital_res_fifo.sv =====
// Result queue: takes up to two results per cycle, gives one per transfer.
// Uses ital_pkg.
module ital_res_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ital_pkg::push_t                   push_i,
  input  logic                              pop_i,
  output ital_pkg::result_t                 head_o,
  output logic                              valid_o,
  output logic [ital_pkg::RES_CNT_W-1:0]    count_o
);

  localparam int unsigned PTR_W = ital_pkg::RES_PTR_W;
  localparam int unsigned CNT_W = ital_pkg::RES_CNT_W;

  ital_pkg::result_t mem_q [ital_pkg::RES_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d;
  logic [PTR_W-1:0]  rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q + PTR_W'(push_i.cnt);
    rd_d  = rd_q + PTR_W'(pop_i);
    cnt_d = cnt_q + CNT_W'(push_i.cnt) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage writes
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + PTR_W'(1)] <= push_i.res1;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;

  // Never overfill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W'(push_i.cnt) + cnt_q) <= CNT_W'(ital_pkg::RES_DEPTH))
    else $error("result queue overflow");

  // Never pop from empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> (cnt_q != '0))
    else $error("result queue underflow");

endmodule

// ===== rtl/indent_aware_token_lexer_unit.sv =====
// Indentation-aware token lexer, top level: input register, tab width
// register, lexer core and result queue. Uses ital_pkg, ital_in_if,
// ital_out_if, ital_core and ital_res_fifo.
//
// The lexer takes one source byte per clock while input ready is high and
// streams token results one per transfer, via the input register and the
// result queue. Most bytes give one result or none; a byte that ends an atom
// or number, or the first non-blank byte of a line, can give two, and the
// output port, moving one result per cycle, then sets the rate. The
// eight-entry result queue decouples the sides: input ready stays high while
// it has room for the results of the byte in flight and the next one.
// tab_width is written through cfg_we_i/cfg_wdata_i only while the block is
// idle, a rule for the user that the block does not enforce; it resets to 4.
module indent_aware_token_lexer_unit #(
  parameter int unsigned INDENT_BITS = ital_pkg::INDENT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [4:0]        cfg_wdata_i,
  ital_in_if.sink           in_i,
  ital_out_if.source        out_o
);

  localparam int unsigned CNT_W = ital_pkg::RES_CNT_W;
  localparam int unsigned SUM_W = CNT_W + 1;

  logic              in_vld_q;
  logic [7:0]        byte_q;
  logic              eoc_q;
  logic [4:0]        tab_width_q;
  logic              in_xfer;
  logic              pop;
  ital_pkg::push_t   push;
  ital_pkg::result_t head;
  logic              head_vld;
  logic [CNT_W-1:0]  fill;
  logic [SUM_W-1:0]  need;

  // Room for the byte in the input register and one more byte
  assign need       = SUM_W'(fill) + (in_vld_q ? SUM_W'(2) : SUM_W'(0)) + SUM_W'(2);
  assign in_i.ready = (need <= SUM_W'(ital_pkg::RES_DEPTH));
  assign in_xfer    = in_i.valid && in_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= in_i.code_byte;
      eoc_q  <= in_i.end_of_code;
    end
  end

  // Tab width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_width_q <= ital_pkg::TAB_WIDTH_RST;
    end else if (cfg_we_i) begin
      tab_width_q <= cfg_wdata_i;
    end
  end

  ital_core #(
    .INDENT_BITS(INDENT_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_vld_i     (in_vld_q),
    .code_byte_i  (byte_q),
    .end_of_code_i(eoc_q),
    .tab_width_i  (tab_width_q),
    .push_o       (push)
  );

  ital_res_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .valid_o(head_vld),
    .count_o(fill)
  );

  // Output channel
  assign pop                = out_o.valid && out_o.ready;
  assign out_o.valid        = head_vld;
  assign out_o.token_kind   = head.token_kind;
  assign out_o.text_byte    = head.text_byte;
  assign out_o.has_text     = head.has_text;
  assign out_o.token_begin  = head.token_begin;
  assign out_o.token_end    = head.token_end;
  assign out_o.indent_width = head.indent_width;
  assign out_o.error_code   = head.error_code;
  assign out_o.last_of_run  = head.last_of_run;

endmodule
